FILE: design/sfr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sfr_pkg;

  localparam int MAX_PAYLOAD_DEFAULT = 256;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 8;

  localparam logic [CFG_INDEX_W-1:0] REG_SYNC_FIRST        = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_SYNC_SECOND       = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_OWN_ADDRESS       = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_BROADCAST_ADDRESS = 2'd3;

  localparam logic [7:0] SYNC_FIRST_RESET        = 8'haa;
  localparam logic [7:0] SYNC_SECOND_RESET       = 8'h55;
  localparam logic [7:0] OWN_ADDRESS_RESET       = 8'h01;
  localparam logic [7:0] BROADCAST_ADDRESS_RESET = 8'hff;

  localparam logic [7:0]  FLAGS_HIGH_MASK = 8'hf0;
  localparam logic [15:0] CRC_INIT        = 16'h1d0f;
  localparam logic [15:0] CRC_POLY        = 16'h1021;

  typedef enum logic [2:0] {
    ERR_NONE      = 3'd0,
    ERR_SYNC      = 3'd1,
    ERR_DEST      = 3'd2,
    ERR_FLAGS     = 3'd3,
    ERR_TOO_LONG  = 3'd4,
    ERR_CRC       = 3'd5
  } err_code_t;

  typedef struct packed {
    logic [7:0] rx_byte;
  } rx_item_t;

  typedef struct packed {
    logic        payload_valid;
    logic [7:0]  payload_byte;
    logic [7:0]  payload_index;
    logic        frame_done;
    logic        frame_error;
    err_code_t   error_code;
    logic [7:0]  source_address;
    logic [3:0]  frame_flags;
    logic [15:0] frame_length;
  } result_t;

  // crc-16, msb first, one byte
  function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] data);
    logic [15:0] r;
    r = crc ^ {data, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (r[15]) begin
        r = {r[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        r = {r[14:0], 1'b0};
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: design/sfr_stream_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface sfr_stream_if #(
  parameter type payload_t = logic [7:0]
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

FILE: design/serial_frame_receiver_crc16.sv
// output: a byte's result is registered in the output register, or in the skid
//   entry while the output is stalled; throughput: one byte per cycle while the
//   skid entry is empty (rx.ready), as the parse and crc update are combinational
// reset: rst is synchronous, active high; it restores the register defaults,
//   returns the parser to the first sync search and empties the result buffer
`timescale 1ns / 1ps
`default_nettype none

module serial_frame_receiver_crc16 #(
  parameter int MAX_PAYLOAD = sfr_pkg::MAX_PAYLOAD_DEFAULT
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_we,
  input  wire logic [sfr_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [sfr_pkg::CFG_DATA_W-1:0]  cfg_data,
  sfr_stream_if.sink                           rx,
  sfr_stream_if.source                         frame
);
  import sfr_pkg::*;

  localparam int CNT_W = $clog2(MAX_PAYLOAD + 1);
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_PAYLOAD);

  typedef enum logic [3:0] {
    PH_SYNC1 = 4'd0,
    PH_SYNC2 = 4'd1,
    PH_DEST  = 4'd2,
    PH_SRC   = 4'd3,
    PH_FLAGS = 4'd4,
    PH_LENH  = 4'd5,
    PH_LENL  = 4'd6,
    PH_DATA  = 4'd7,
    PH_CRCH  = 4'd8,
    PH_CRCL  = 4'd9
  } phase_t;

  logic [7:0] sync_first;
  logic [7:0] sync_second;
  logic [7:0] own_address;
  logic [7:0] broadcast_address;

  phase_t           phase, phase_next;
  logic [15:0]      crc, crc_next;
  logic [15:0]      length, length_next;
  logic [CNT_W-1:0] count, count_next;
  logic [CNT_W-1:0] count_inc;
  logic [7:0]       source, source_next;
  logic [3:0]       flags, flags_next;
  logic [7:0]       crc_high, crc_high_next;

  result_t   res;
  result_t   out_res;
  result_t   skid_res;
  logic      out_valid;
  logic      skid_full;
  logic      has_res;
  logic      take;
  logic      out_free;
  logic      frame_end;
  err_code_t code;
  logic [7:0] b;
  logic [15:0] crc_fed;

  assign b        = rx.payload.rx_byte;
  assign crc_fed  = crc_feed(crc, b);
  assign count_inc = count + 1'b1;
  assign rx.ready = !skid_full;
  assign take     = rx.valid && rx.ready;
  assign out_free = !out_valid || frame.ready;

  assign frame.valid   = out_valid;
  assign frame.payload = out_res;

  always_comb begin
    phase_next    = phase;
    crc_next      = crc;
    length_next   = length;
    count_next    = count;
    source_next   = source;
    flags_next    = flags;
    crc_high_next = crc_high;
    code          = ERR_NONE;
    frame_end     = 1'b0;
    has_res       = 1'b1;
    res           = '0;

    unique case (phase)
      PH_SYNC1: begin
        if (b == sync_first) begin
          crc_next   = crc_fed;
          phase_next = PH_SYNC2;
        end else begin
          code = ERR_SYNC;
        end
      end
      PH_SYNC2: begin
        if (b == sync_second) begin
          crc_next   = crc_fed;
          phase_next = PH_DEST;
        end else begin
          code = ERR_SYNC;
        end
      end
      PH_DEST: begin
        if (b == own_address || b == broadcast_address) begin
          crc_next   = crc_fed;
          phase_next = PH_SRC;
        end else begin
          code = ERR_DEST;
        end
      end
      PH_SRC: begin
        source_next = b;
        crc_next    = crc_fed;
        phase_next  = PH_FLAGS;
      end
      PH_FLAGS: begin
        flags_next = b[3:0];
        if ((b & FLAGS_HIGH_MASK) != 8'h00) begin
          code = ERR_FLAGS;
        end else begin
          crc_next   = crc_fed;
          phase_next = PH_LENH;
        end
      end
      PH_LENH: begin
        length_next = {b, 8'h00};
        crc_next    = crc_fed;
        phase_next  = PH_LENL;
      end
      PH_LENL: begin
        length_next = {length[15:8], b};
        crc_next    = crc_fed;
        count_next  = '0;
        phase_next  = ({length[15:8], b} == 16'h0000) ? PH_CRCH : PH_DATA;
      end
      PH_DATA: begin
        if (count_inc >= MAX_CNT && 16'(count_inc) != length) begin
          code = ERR_TOO_LONG;
        end else begin
          res.payload_valid = 1'b1;
          res.payload_byte  = b;
          res.payload_index = 8'(count);
          crc_next          = crc_fed;
          count_next        = count_inc;
          if (16'(count_inc) == length) begin
            phase_next = PH_CRCH;
          end
        end
      end
      PH_CRCH: begin
        crc_high_next = b;
        phase_next    = PH_CRCL;
      end
      PH_CRCL: begin
        if ({crc_high, b} == crc) begin
          res.frame_done = 1'b1;
        end else begin
          code = ERR_CRC;
        end
        frame_end = 1'b1;
      end
      default: begin
        has_res   = 1'b0;
        frame_end = 1'b1;
      end
    endcase

    res.frame_error    = (code != ERR_NONE);
    res.error_code     = code;
    res.source_address = source_next;
    res.frame_flags    = flags_next;
    res.frame_length   = length_next;

    if (frame_end || code != ERR_NONE) begin
      phase_next  = PH_SYNC1;
      crc_next    = CRC_INIT;
      length_next = '0;
      count_next  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sync_first        <= SYNC_FIRST_RESET;
      sync_second       <= SYNC_SECOND_RESET;
      own_address       <= OWN_ADDRESS_RESET;
      broadcast_address <= BROADCAST_ADDRESS_RESET;
      phase             <= PH_SYNC1;
      crc               <= CRC_INIT;
      length            <= '0;
      count             <= '0;
      source            <= '0;
      flags             <= '0;
      crc_high          <= '0;
      out_valid         <= 1'b0;
      skid_full         <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_SYNC_FIRST:        sync_first        <= cfg_data;
          REG_SYNC_SECOND:       sync_second       <= cfg_data;
          REG_OWN_ADDRESS:       own_address       <= cfg_data;
          REG_BROADCAST_ADDRESS: broadcast_address <= cfg_data;
          default: ;
        endcase
      end

      if (take) begin
        phase    <= phase_next;
        crc      <= crc_next;
        length   <= length_next;
        count    <= count_next;
        source   <= source_next;
        flags    <= flags_next;
        crc_high <= crc_high_next;
      end

      // output register with skid stage
      if (out_free) begin
        if (skid_full) begin
          out_res   <= skid_res;
          out_valid <= 1'b1;
          skid_full <= 1'b0;
        end else begin
          out_res   <= res;
          out_valid <= take && has_res;
        end
      end else if (take && has_res) begin
        skid_res  <= res;
        skid_full <= 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

FILE: bench/serial_frame_receiver_crc16_tb.sv
`timescale 1ns / 1ps

module serial_frame_receiver_crc16_tb;
  import sfr_pkg::*;

  localparam int MAX_PAYLOAD = MAX_PAYLOAD_DEFAULT;
  localparam int PHASE_BYTES = 220;
  localparam int HOLD_CYCLES = 400;
  localparam int CYCLE_LIMIT = 200000;

  typedef enum logic [3:0] {
    SEEK_FIRST, SEEK_SECOND, GET_DEST, GET_SRC, GET_FLAGS,
    GET_LEN_HI, GET_LEN_LO, GET_DATA, GET_CRC_HI, GET_CRC_LO
  } frame_phase_t;

  typedef enum logic [1:0] {
    PACE_FULL, PACE_SENDER_IDLE, PACE_RECEIVER_STALL, PACE_BOTH
  } pace_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  sfr_stream_if #(.payload_t(rx_item_t)) rx_if ();
  sfr_stream_if #(.payload_t(result_t)) frame_if ();

  serial_frame_receiver_crc16 #(.MAX_PAYLOAD(MAX_PAYLOAD)) dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .rx(rx_if),
    .frame(frame_if)
  );

  always begin
    #6;
    clk = 1'b1;
    #6;
    clk = 1'b0;
  end

  // register mirror
  logic [7:0] cfg_sync_first = SYNC_FIRST_RESET;
  logic [7:0] cfg_sync_second = SYNC_SECOND_RESET;
  logic [7:0] cfg_own_addr = OWN_ADDRESS_RESET;
  logic [7:0] cfg_bcast_addr = BROADCAST_ADDRESS_RESET;

  // parser mirror
  frame_phase_t rx_phase = SEEK_FIRST;
  logic [15:0] rx_crc = CRC_INIT;
  logic [15:0] rx_len = '0;
  logic [8:0] rx_count = '0;
  logic [7:0] rx_src = '0;
  logic [3:0] rx_flags = '0;
  logic [7:0] rx_crc_hi = '0;

  rx_item_t pending_bytes[$];
  result_t expected_results[$];

  pace_t pace = PACE_FULL;
  bit rx_fired = 1'b0;
  bit hold_request = 1'b0;
  int unsigned hold_left = 0;
  int unsigned cycle_count = 0;
  int unsigned bytes_queued = 0;
  int unsigned results_checked = 0;
  int unsigned frames_passed = 0;
  int unsigned frames_aborted = 0;
  int unsigned payload_seen = 0;
  int unsigned failures = 0;

  function automatic logic [15:0] crc16_step(input logic [15:0] c, input logic [7:0] d);
    logic [15:0] acc;
    logic fb;
    acc = c;
    for (int k = 7; k >= 0; k--) begin
      fb = acc[15] ^ d[k];
      acc = {acc[14:0], 1'b0};
      if (fb) begin
        acc = acc ^ CRC_POLY;
      end
    end
    return acc;
  endfunction

  function automatic void restart_parse();
    rx_phase = SEEK_FIRST;
    rx_crc = CRC_INIT;
    rx_len = '0;
    rx_count = '0;
  endfunction

  function automatic result_t parse_byte(input logic [7:0] b);
    result_t r;
    err_code_t code;
    bit ended;
    r = '0;
    code = ERR_NONE;
    ended = 1'b0;
    case (rx_phase)
      SEEK_FIRST: begin
        if (b == cfg_sync_first) begin
          rx_crc = crc16_step(rx_crc, b);
          rx_phase = SEEK_SECOND;
        end else begin
          code = ERR_SYNC;
        end
      end
      SEEK_SECOND: begin
        if (b == cfg_sync_second) begin
          rx_crc = crc16_step(rx_crc, b);
          rx_phase = GET_DEST;
        end else begin
          code = ERR_SYNC;
        end
      end
      GET_DEST: begin
        if (b == cfg_own_addr || b == cfg_bcast_addr) begin
          rx_crc = crc16_step(rx_crc, b);
          rx_phase = GET_SRC;
        end else begin
          code = ERR_DEST;
        end
      end
      GET_SRC: begin
        rx_src = b;
        rx_crc = crc16_step(rx_crc, b);
        rx_phase = GET_FLAGS;
      end
      GET_FLAGS: begin
        rx_flags = b[3:0];
        if ((b & FLAGS_HIGH_MASK) != 0) begin
          code = ERR_FLAGS;
        end else begin
          rx_crc = crc16_step(rx_crc, b);
          rx_phase = GET_LEN_HI;
        end
      end
      GET_LEN_HI: begin
        rx_len = {b, 8'h00};
        rx_crc = crc16_step(rx_crc, b);
        rx_phase = GET_LEN_LO;
      end
      GET_LEN_LO: begin
        rx_len = {rx_len[15:8], b};
        rx_crc = crc16_step(rx_crc, b);
        rx_count = '0;
        rx_phase = (rx_len == 0) ? GET_CRC_HI : GET_DATA;
      end
      GET_DATA: begin
        if (rx_count + 1 >= MAX_PAYLOAD && rx_count + 1 != rx_len) begin
          code = ERR_TOO_LONG;
        end else begin
          r.payload_valid = 1'b1;
          r.payload_byte = b;
          r.payload_index = rx_count[7:0];
          rx_crc = crc16_step(rx_crc, b);
          rx_count = rx_count + 1'b1;
          if (rx_count == rx_len) begin
            rx_phase = GET_CRC_HI;
          end
        end
      end
      GET_CRC_HI: begin
        rx_crc_hi = b;
        rx_phase = GET_CRC_LO;
      end
      default: begin
        if ({rx_crc_hi, b} == rx_crc) begin
          r.frame_done = 1'b1;
        end else begin
          code = ERR_CRC;
        end
        ended = 1'b1;
      end
    endcase
    r.frame_error = (code != ERR_NONE);
    r.error_code = code;
    r.source_address = rx_src;
    r.frame_flags = rx_flags;
    r.frame_length = rx_len;
    if (ended || code != ERR_NONE) begin
      restart_parse();
    end
    return r;
  endfunction

  function automatic bit field_ok(input string name, input logic [15:0] want,
                                  input logic [15:0] got);
    if (want !== got) begin
      $display("%0t ns: %s mismatch, expected %h, actual %h", $time, name, want, got);
      return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic void compare_result(input result_t want, input result_t got);
    bit ok;
    ok = 1'b1;
    ok &= field_ok("payload_valid", 16'(want.payload_valid), 16'(got.payload_valid));
    ok &= field_ok("payload_byte", 16'(want.payload_byte), 16'(got.payload_byte));
    ok &= field_ok("payload_index", 16'(want.payload_index), 16'(got.payload_index));
    ok &= field_ok("frame_done", 16'(want.frame_done), 16'(got.frame_done));
    ok &= field_ok("frame_error", 16'(want.frame_error), 16'(got.frame_error));
    ok &= field_ok("error_code", 16'(want.error_code), 16'(got.error_code));
    ok &= field_ok("source_address", 16'(want.source_address), 16'(got.source_address));
    ok &= field_ok("frame_flags", 16'(want.frame_flags), 16'(got.frame_flags));
    ok &= field_ok("frame_length", want.frame_length, got.frame_length);
    if (!ok) begin
      failures++;
    end
  endfunction

  function automatic bit roll(input int unsigned pct);
    return $urandom_range(0, 99) < pct;
  endfunction

  function automatic int unsigned sender_idle_pct(input pace_t p);
    case (p)
      PACE_SENDER_IDLE: return 59;
      PACE_BOTH: return 16;
      default: return 0;
    endcase
  endfunction

  function automatic int unsigned receiver_stall_pct(input pace_t p);
    case (p)
      PACE_RECEIVER_STALL: return 59;
      PACE_BOTH: return 16;
      default: return 0;
    endcase
  endfunction

  // sender
  always @(negedge clk) begin
    if (rst) begin
      rx_if.valid <= 1'b0;
    end else if (!rx_if.valid || rx_fired) begin
      if (pending_bytes.size() != 0 && !roll(sender_idle_pct(pace))) begin
        rx_if.valid <= 1'b1;
        rx_if.payload <= pending_bytes.pop_front();
      end else begin
        rx_if.valid <= 1'b0;
      end
    end
  end

  // receiver, with a long hold-off on request
  always @(negedge clk) begin
    if (rst) begin
      frame_if.ready <= 1'b0;
    end else if (hold_left > 0) begin
      frame_if.ready <= 1'b0;
      hold_left = hold_left - 1;
    end else if (hold_request) begin
      frame_if.ready <= 1'b0;
      hold_request = 1'b0;
      hold_left = HOLD_CYCLES - 1;
    end else begin
      frame_if.ready <= !roll(receiver_stall_pct(pace));
    end
  end

  // transaction monitor
  always @(posedge clk) begin
    result_t want;
    rx_fired = 1'b0;
    if (!rst) begin
      if (frame_if.valid && frame_if.ready) begin
        if (expected_results.size() == 0) begin
          $display("%0t ns: result with nothing expected, actual %h", $time, frame_if.payload);
          failures++;
        end else begin
          want = expected_results.pop_front();
          compare_result(want, frame_if.payload);
        end
        results_checked++;
        if (frame_if.payload.payload_valid) payload_seen++;
        if (frame_if.payload.frame_done) frames_passed++;
        if (frame_if.payload.frame_error) frames_aborted++;
      end
      if (rx_if.valid && rx_if.ready) begin
        expected_results.push_back(parse_byte(rx_if.payload.rx_byte));
        rx_fired = 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t ns: timeout, %0d results still expected", $time, expected_results.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [7:0] value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    case (idx)
      REG_SYNC_FIRST: cfg_sync_first = value;
      REG_SYNC_SECOND: cfg_sync_second = value;
      REG_OWN_ADDRESS: cfg_own_addr = value;
      default: cfg_bcast_addr = value;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_registers(input logic [7:0] s1, input logic [7:0] s2,
                               input logic [7:0] own, input logic [7:0] bcast);
    write_reg(REG_SYNC_FIRST, s1);
    write_reg(REG_SYNC_SECOND, s2);
    write_reg(REG_OWN_ADDRESS, own);
    write_reg(REG_BROADCAST_ADDRESS, bcast);
  endtask

  task automatic drain();
    while (pending_bytes.size() != 0 || rx_if.valid || expected_results.size() != 0) begin
      @(negedge clk);
    end
    repeat (2) @(negedge clk);
  endtask

  task automatic offer_byte(input logic [7:0] b);
    pending_bytes.push_back(b);
    bytes_queued++;
  endtask

  task automatic queue_frame(input logic [7:0] dest, input logic [7:0] flag_byte,
                             input logic [15:0] length, input int unsigned body,
                             input bit corrupt);
    logic [7:0] head [7];
    logic [15:0] crc;
    logic [7:0] b;
    crc = CRC_INIT;
    b = 8'($urandom_range(0, 255));
    head = '{cfg_sync_first, cfg_sync_second, dest, b, flag_byte, length[15:8], length[7:0]};
    foreach (head[i]) begin
      crc = crc16_step(crc, head[i]);
      offer_byte(head[i]);
    end
    for (int i = 0; i < body; i++) begin
      b = 8'($urandom_range(0, 255));
      crc = crc16_step(crc, b);
      offer_byte(b);
    end
    if (corrupt) begin
      crc = crc ^ (16'h0001 << $urandom_range(0, 15));
    end
    offer_byte(crc[15:8]);
    offer_byte(crc[7:0]);
  endtask

  function automatic logic [7:0] good_dest();
    return roll(50) ? cfg_own_addr : cfg_bcast_addr;
  endfunction

  function automatic logic [7:0] foreign_dest();
    logic [7:0] d;
    d = 8'($urandom_range(0, 255));
    while (d == cfg_own_addr || d == cfg_bcast_addr) begin
      d = 8'($urandom_range(0, 255));
    end
    return d;
  endfunction

  function automatic logic [15:0] pick_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 15) return 16'd0;
    if (r < 85) return 16'($urandom_range(1, 16));
    return 16'($urandom_range(17, 64));
  endfunction

  task automatic queue_traffic(input int unsigned amount);
    int unsigned stop;
    int unsigned r;
    logic [15:0] len;
    logic [7:0] b;
    stop = bytes_queued + amount;
    while (bytes_queued < stop) begin
      r = $urandom_range(0, 99);
      len = pick_len();
      if (r < 60) begin
        queue_frame(good_dest(), 8'($urandom_range(0, 15)), len, 32'(len), r < 7);
      end else if (r < 68) begin
        queue_frame(foreign_dest(), 8'($urandom_range(0, 15)), len, 32'(len), 1'b0);
      end else if (r < 76) begin
        queue_frame(good_dest(), 8'($urandom_range(16, 255)), len, 32'(len), 1'b0);
      end else if (r < 82) begin
        offer_byte(cfg_sync_first);
        b = 8'($urandom_range(0, 255));
        while (b == cfg_sync_second) b = 8'($urandom_range(0, 255));
        offer_byte(b);
      end else if (r < 90) begin
        queue_frame(good_dest(), 8'($urandom_range(0, 15)), len, $urandom_range(0, len), 1'b0);
      end else begin
        repeat ($urandom_range(1, 8)) begin
          case ($urandom_range(0, 3))
            0: offer_byte(cfg_sync_first);
            1: offer_byte(cfg_sync_second);
            default: offer_byte(8'($urandom_range(0, 255)));
          endcase
        end
      end
    end
  endtask

  initial begin
    logic [7:0] v;
    rx_if.valid = 1'b0;
    rx_if.payload = '0;
    frame_if.ready = 1'b0;
    repeat (4) @(negedge clk);
    rst <= 1'b0;

    // reset register values, directed cases first
    pace = PACE_FULL;
    offer_byte(8'h00);
    offer_byte(SYNC_FIRST_RESET);
    offer_byte(SYNC_SECOND_RESET);
    offer_byte(8'h07);
    offer_byte(SYNC_FIRST_RESET);
    offer_byte(SYNC_SECOND_RESET);
    offer_byte(OWN_ADDRESS_RESET);
    offer_byte(8'h3c);
    offer_byte(8'hf5);
    queue_frame(BROADCAST_ADDRESS_RESET, 8'h0f, 16'd0, 0, 1'b0);
    queue_frame(OWN_ADDRESS_RESET, 8'h00, 16'd1, 1, 1'b1);
    queue_traffic(PHASE_BYTES);
    drain();

    set_registers(8'h00, 8'hff, 8'h00, 8'hff);
    pace = PACE_SENDER_IDLE;
    queue_traffic(PHASE_BYTES);
    drain();

    set_registers(8'hff, 8'h00, 8'hff, 8'h00);
    pace = PACE_RECEIVER_STALL;
    queue_traffic(PHASE_BYTES);
    drain();

    // own and broadcast address equal
    v = 8'($urandom_range(0, 255));
    set_registers(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), v, v);
    pace = PACE_BOTH;
    queue_traffic(PHASE_BYTES);
    drain();

    // equal sync bytes, longest payload, over-long frame, long receiver hold-off
    v = 8'($urandom_range(0, 255));
    set_registers(v, v, 8'($urandom_range(0, 127)), 8'($urandom_range(128, 255)));
    pace = PACE_FULL;
    queue_frame(cfg_own_addr, 8'h00, 16'd256, 256, 1'b0);
    hold_request = 1'b1;
    queue_frame(cfg_bcast_addr, 8'h0a, 16'hffff, 258, 1'b0);
    queue_traffic(200);
    drain();
    repeat (4) @(negedge clk);

    $display("%0d bytes sent over five register settings, %0d results checked",
             bytes_queued, results_checked);
    $display("%0d frames passed crc, %0d aborted, %0d payload bytes streamed",
             frames_passed, frames_aborted, payload_seen);
    if (failures == 0 && expected_results.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
